// ===== src/uvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

   localparam int VOCAB_ENTRIES_DEF   = 4096;
   localparam int MAX_PIECE_BYTES_DEF = 8;
   localparam int MAX_WORD_BYTES_DEF  = 32;

   localparam int ID_W    = 12;
   localparam int COST_W  = 24;
   localparam int PCOST_W = 16;
   localparam int LEN_W   = 4;
   localparam int EXCL_W  = 13;

   localparam logic [COST_W-1:0] COST_SAT = 24'hFFFFFF;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNREACH = 2'd1;
   localparam logic [1:0] ST_LONG    = 2'd2;

   // keeps the low len bytes of a 64-bit piece text
   function automatic logic [63:0] len_mask(input logic [LEN_W-1:0] len);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (LEN_W'(b) < len) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== src/unigram_viterbi_segmenter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Unigram Viterbi segmenter. Opcode 0 writes one token table entry, opcode 2 clears the
// table, opcode 1 streams word bytes. After reset and after every clear the table memory is
// swept one entry a cycle with req_stall high. The final byte starts the search: for every
// reachable byte position the table memory is scanned once through its single read port,
// matching all piece lengths in parallel lanes, then each piece length is relaxed into the
// path-cost memory by a read-modify-write; unreachable positions are skipped. A traceback of
// the chosen tokens follows when the path is wanted. Results are either the token ids in word
// order with the total cost, or the total cost alone, or one status beat for an unreachable
// or too-long word; req_stall stays high until the last beat of a word has entered the output
// register.
module unigram_viterbi_segmenter #(
   parameter int VOCAB_ENTRIES   = uvs_pkg::VOCAB_ENTRIES_DEF,
   parameter int MAX_PIECE_BYTES = uvs_pkg::MAX_PIECE_BYTES_DEF,
   parameter int MAX_WORD_BYTES  = uvs_pkg::MAX_WORD_BYTES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [uvs_pkg::ID_W-1:0]     req_entry_id,
   input  wire logic [63:0]                  req_entry_bytes,
   input  wire logic [uvs_pkg::LEN_W-1:0]    req_entry_length,
   input  wire logic [uvs_pkg::PCOST_W-1:0]  req_entry_cost,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_last_byte,
   input  wire logic signed [uvs_pkg::EXCL_W-1:0] req_exclude_id,
   input  wire logic                         req_path_wanted,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [uvs_pkg::ID_W-1:0]          rsp_token_id,
   output logic [uvs_pkg::COST_W-1:0]        rsp_total_cost,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last_result
);
   import uvs_pkg::*;

   localparam int AW  = $clog2(VOCAB_ENTRIES);
   localparam int TW  = 8 * MAX_PIECE_BYTES;
   localparam int PW  = $clog2(MAX_WORD_BYTES + 1);
   localparam int WIW = $clog2(MAX_WORD_BYTES);
   localparam int LW  = (MAX_PIECE_BYTES > 1) ? $clog2(MAX_PIECE_BYTES) : 1;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [TW-1:0]      text;
      logic [PCOST_W-1:0] cost;
   } tent_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [PW-1:0]     start;
      logic [ID_W-1:0]   piece;
   } bent_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_POS, S_SCAN, S_DRAIN, S_RELAX_RD, S_RELAX_WR, S_NEXT,
      S_END_RD, S_END, S_TRACE_RD, S_TRACE, S_EMIT_RD, S_EMIT
   } state_type;

   state_type state_ff;

   // table memory
   tent_type tmem [VOCAB_ENTRIES];
   tent_type tq_ff;
   logic     tm_we;
   logic [AW-1:0] tm_waddr;
   tent_type tm_wdata;

   // path cost memory
   bent_type bmem [MAX_WORD_BYTES + 1];
   bent_type bq_ff;
   logic     bm_we;
   logic [PW-1:0] bm_raddr;
   logic [PW-1:0] bm_waddr;
   bent_type bm_wdata;

   // traceback stack
   logic [ID_W-1:0] pmem [MAX_WORD_BYTES];
   logic [ID_W-1:0] pq_ff;
   logic [PW-1:0]   pm_ridx;

   logic [7:0]       wbyte_ff [MAX_WORD_BYTES];
   logic [PW-1:0]    wlen_ff;
   logic             ovf_ff;
   logic [MAX_WORD_BYTES:0] reach_ff;
   logic [LEN_W-1:0] longest_ff;
   logic [AW-1:0]    clr_ff;
   logic [AW-1:0]    scan_ff;
   logic [AW-1:0]    tidx_ff;
   logic             tv_ff;
   logic [PW-1:0]    s_ff;
   logic [LW-1:0]    li_ff;
   logic [COST_W-1:0] base_ff;
   logic [COST_W-1:0] total_ff;
   logic [PW-1:0]    pos_ff;
   logic [PW-1:0]    cnt_ff;
   logic signed [EXCL_W-1:0] excl_ff;
   logic             path_ff;

   logic [MAX_PIECE_BYTES-1:0] found_ff;
   logic [ID_W-1:0]    lane_id_ff   [MAX_PIECE_BYTES];
   logic [PCOST_W-1:0] lane_cost_ff [MAX_PIECE_BYTES];

   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_token_id_ff;
   logic [COST_W-1:0] rsp_total_cost_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_last_result_ff;

   logic              out_free;
   logic              end_short;
   logic              rsp_set;
   logic              req_fire;
   logic              load_ok;
   logic [LEN_W-1:0]  load_len;
   logic [TW-1:0]     win;
   logic [PW:0]       end_pos;
   logic [LEN_W-1:0]  cur_len;
   logic              lane_elig;
   logic              excluded;
   logic [COST_W:0]   cand_sum;
   logic [COST_W-1:0] cand;
   logic              better;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a new beat enters the output register this cycle
   assign end_short = ovf_ff || !reach_ff[wlen_ff] || !path_ff;
   assign rsp_set   = out_free && ((state_ff == S_END && end_short) || state_ff == S_EMIT);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_id    = rsp_token_id_ff;
   assign rsp_total_cost  = rsp_total_cost_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_result_ff;

   assign load_ok  = (32'(req_entry_id) < VOCAB_ENTRIES);
   assign load_len = (req_entry_length > LEN_W'(MAX_PIECE_BYTES)) ? '0 : req_entry_length;

   always_comb begin
      for (int b = 0; b < MAX_PIECE_BYTES; b++) begin
         win[b*8 +: 8] = wbyte_ff[b];
      end
   end

   // lane under relaxation
   assign cur_len   = LEN_W'(li_ff) + LEN_W'(1);
   assign end_pos   = {1'b0, s_ff} + (PW+1)'(li_ff) + (PW+1)'(1);
   assign excluded  = !excl_ff[EXCL_W-1] && (excl_ff[ID_W-1:0] == lane_id_ff[li_ff]);
   assign lane_elig = found_ff[li_ff] && !excluded && (cur_len <= longest_ff)
                      && (end_pos <= {1'b0, wlen_ff});
   assign cand_sum  = {1'b0, base_ff} + (COST_W+1)'(lane_cost_ff[li_ff]);
   assign cand      = cand_sum[COST_W] ? COST_SAT : cand_sum[COST_W-1:0];
   assign better    = !reach_ff[PW'(end_pos)] || (cand < bq_ff.cost);

   assign pm_ridx = cnt_ff - PW'(1);

   always_comb begin
      tm_we    = 1'b0;
      tm_waddr = clr_ff;
      tm_wdata = '0;
      if (state_ff == S_CLEAR) begin
         tm_we = 1'b1;
      end else if (req_fire && req_opcode == OP_LOAD && load_ok) begin
         tm_we         = 1'b1;
         tm_waddr      = AW'(req_entry_id);
         tm_wdata.len  = load_len;
         tm_wdata.text = TW'(req_entry_bytes & len_mask(load_len));
         tm_wdata.cost = req_entry_cost;
      end
   end

   always_comb begin
      case (state_ff)
         S_RELAX_RD: bm_raddr = PW'(end_pos);
         S_END_RD:   bm_raddr = wlen_ff;
         S_TRACE_RD: bm_raddr = pos_ff;
         default:    bm_raddr = s_ff;
      endcase
      bm_we          = (state_ff == S_RELAX_WR) && better;
      bm_waddr       = PW'(end_pos);
      bm_wdata.cost  = cand;
      bm_wdata.start = s_ff;
      bm_wdata.piece = lane_id_ff[li_ff];
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         tmem[tm_waddr] <= tm_wdata;
      end
      tq_ff <= tmem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bmem[bm_waddr] <= bm_wdata;
      end
      bq_ff <= bmem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_TRACE) begin
         pmem[cnt_ff[WIW-1:0]] <= bq_ff.piece;
      end
      pq_ff <= pmem[pm_ridx[WIW-1:0]];
   end

   // word bytes; shifted down one byte per finished position so lanes see fixed taps
   always_ff @(posedge clock) begin
      if (req_fire && req_opcode == OP_BYTE && wlen_ff < PW'(MAX_WORD_BYTES)) begin
         wbyte_ff[wlen_ff[WIW-1:0]] <= req_data_byte;
      end else if (state_ff == S_NEXT) begin
         for (int i = 0; i < MAX_WORD_BYTES - 1; i++) begin
            wbyte_ff[i] <= wbyte_ff[i+1];
         end
         wbyte_ff[MAX_WORD_BYTES-1] <= '0;
      end
   end

   // first matching entry per piece length
   always_ff @(posedge clock) begin
      if (state_ff == S_POS) begin
         found_ff <= '0;
      end else if (tv_ff) begin
         for (int i = 0; i < MAX_PIECE_BYTES; i++) begin
            if (!found_ff[i] && tq_ff.len == LEN_W'(i + 1)
                && tq_ff.text == (win & TW'(len_mask(LEN_W'(i + 1))))) begin
               found_ff[i]     <= 1'b1;
               lane_id_ff[i]   <= ID_W'(tidx_ff);
               lane_cost_ff[i] <= tq_ff.cost;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         longest_ff   <= '0;
         wlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         reach_ff     <= (MAX_WORD_BYTES+1)'(1);
         tv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_set) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == AW'(VOCAB_ENTRIES - 1)) begin
                  clr_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  case (req_opcode)
                     OP_LOAD: begin
                        if (load_ok && load_len > longest_ff) begin
                           longest_ff <= load_len;
                        end
                     end
                     OP_CLEAR: begin
                        longest_ff <= '0;
                        state_ff   <= S_CLEAR;
                     end
                     OP_BYTE: begin
                        if (wlen_ff < PW'(MAX_WORD_BYTES)) begin
                           wlen_ff <= wlen_ff + PW'(1);
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                        if (req_last_byte) begin
                           excl_ff  <= req_exclude_id;
                           path_ff  <= req_path_wanted;
                           s_ff     <= '0;
                           state_ff <= S_POS;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_POS: begin
               if (ovf_ff || s_ff == wlen_ff) begin
                  state_ff <= S_END_RD;
               end else if (!reach_ff[s_ff]) begin
                  state_ff <= S_NEXT;
               end else begin
                  scan_ff  <= '0;
                  tv_ff    <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               scan_ff <= scan_ff + AW'(1);
               tidx_ff <= scan_ff;
               tv_ff   <= 1'b1;
               if (scan_ff == AW'(VOCAB_ENTRIES - 1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               tv_ff    <= 1'b0;
               // position zero always starts at cost zero
               base_ff  <= (s_ff == '0) ? '0 : bq_ff.cost;
               li_ff    <= '0;
               state_ff <= S_RELAX_RD;
            end
            S_RELAX_RD: begin
               if (lane_elig) begin
                  state_ff <= S_RELAX_WR;
               end else if (li_ff == LW'(MAX_PIECE_BYTES - 1)) begin
                  state_ff <= S_NEXT;
               end else begin
                  li_ff <= li_ff + LW'(1);
               end
            end
            S_RELAX_WR: begin
               if (better) begin
                  reach_ff[PW'(end_pos)] <= 1'b1;
               end
               if (li_ff == LW'(MAX_PIECE_BYTES - 1)) begin
                  state_ff <= S_NEXT;
               end else begin
                  li_ff    <= li_ff + LW'(1);
                  state_ff <= S_RELAX_RD;
               end
            end
            S_NEXT: begin
               s_ff     <= s_ff + PW'(1);
               state_ff <= S_POS;
            end
            S_END_RD: begin
               state_ff <= S_END;
            end
            S_END: begin
               if (out_free) begin
                  rsp_token_id_ff    <= '0;
                  rsp_last_result_ff <= 1'b1;
                  if (ovf_ff) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_total_cost_ff <= '0;
                     rsp_status_ff     <= ST_LONG;
                  end else if (!reach_ff[wlen_ff]) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_total_cost_ff <= COST_SAT;
                     rsp_status_ff     <= ST_UNREACH;
                  end else if (!path_ff) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_total_cost_ff <= bq_ff.cost;
                     rsp_status_ff     <= ST_OK;
                  end
                  if (ovf_ff || !reach_ff[wlen_ff] || !path_ff) begin
                     wlen_ff  <= '0;
                     ovf_ff   <= 1'b0;
                     reach_ff <= (MAX_WORD_BYTES+1)'(1);
                     state_ff <= S_IDLE;
                  end else begin
                     total_ff <= bq_ff.cost;
                     pos_ff   <= wlen_ff;
                     cnt_ff   <= '0;
                     state_ff <= S_TRACE_RD;
                  end
               end
            end
            S_TRACE_RD: begin
               state_ff <= S_TRACE;
            end
            S_TRACE: begin
               cnt_ff <= cnt_ff + PW'(1);
               pos_ff <= bq_ff.start;
               state_ff <= (bq_ff.start == '0) ? S_EMIT_RD : S_TRACE_RD;
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_token_id_ff    <= pq_ff;
                  rsp_total_cost_ff  <= total_ff;
                  rsp_status_ff      <= ST_OK;
                  rsp_last_result_ff <= (cnt_ff == PW'(1));
                  cnt_ff             <= cnt_ff - PW'(1);
                  if (cnt_ff == PW'(1)) begin
                     wlen_ff  <= '0;
                     ovf_ff   <= 1'b0;
                     reach_ff <= (MAX_WORD_BYTES+1)'(1);
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/uvs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module uvs_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [uvs_pkg::ID_W-1:0]     rsp_token_id,
   input wire logic [uvs_pkg::COST_W-1:0]   rsp_total_cost,
   input wire logic [1:0]                   rsp_status,
   input wire logic                         rsp_last_result
);
   import uvs_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_id)
      && $stable(rsp_total_cost) && $stable(rsp_status) && $stable(rsp_last_result))
      else $error("result beat changed while stalled");

   a_unreach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNREACH |->
      rsp_total_cost == COST_SAT && rsp_token_id == '0 && rsp_last_result)
      else $error("unreachable word beat malformed");

   a_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LONG |->
      rsp_total_cost == '0 && rsp_token_id == '0 && rsp_last_result)
      else $error("too long word beat malformed");

   // beats of one path share the same total
   a_path_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_result |=>
      !rsp_valid || (rsp_total_cost == $past(rsp_total_cost) && rsp_status == ST_OK))
      else $error("path beats disagree on total");

endmodule

bind unigram_viterbi_segmenter uvs_checker u_uvs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_token_id    (rsp_token_id),
   .rsp_total_cost  (rsp_total_cost),
   .rsp_status      (rsp_status),
   .rsp_last_result (rsp_last_result)
);
`default_nettype wire
